// ===== rtl/assert_macros.svh =====
// Assertion helpers for the exponentiation block.
// ME_ASSERT checks a property on the clock edge and skips it while reset is applied.
// ME_ASSERT_NR checks a property on every clock edge, with no reset qualifier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ME_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ME_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ME_ASSERT(lbl, clk, rstn, prop, msg)
`define ME_ASSERT_NR(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/me_pkg.sv =====
`default_nettype none

package me_pkg;

  localparam int unsigned MOD_W        = 31;
  localparam int unsigned BASE_W       = 32;
  localparam int unsigned EXP_W        = 63;
  localparam int unsigned EXP_BITS_DEF = 63;
  localparam int unsigned STEP_W       = $clog2(BASE_W);

  localparam logic [MOD_W-1:0] MODULUS_RESET = 31'd1000000007;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_LOAD,
    ST_MUL,
    ST_STORE,
    ST_FINISH
  } me_state_e;

  typedef struct packed {
    logic clr;       // clear both multiplier remainders
    logic step;      // advance both multipliers by one multiplier bit
    logic mbit;      // current multiplier bit, MSB first
    logic reduce;    // base reduction pass: square unit multiplicand is one
    logic upd_sq;    // take the square unit result
    logic upd_acc;   // take the accumulator unit result
    logic init;      // start of an item: preset the accumulator
    logic zero;      // preset the accumulator to zero instead of one
    logic out_load;  // move the accumulator into the output register
  } me_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/me_mulmod.sv =====
`default_nettype none

// Bit-serial modular multiplier: r = (2r + bit*a) mod m per step, multiplier MSB first.
// Needs a < m; the remainder then stays below m.
module me_mulmod import me_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             clr_i,
  input  wire logic             step_i,
  input  wire logic             bit_i,
  input  wire logic [MOD_W-1:0] a_i,
  input  wire logic [MOD_W-1:0] m_i,
  output logic      [MOD_W-1:0] r_o
);

  logic [MOD_W-1:0] r_q;
  logic [MOD_W-1:0] r_d;
  logic [MOD_W+1:0] sum;
  logic [MOD_W+1:0] m1;
  logic [MOD_W+1:0] m2;

  always_comb begin
    m1  = {2'b00, m_i};
    m2  = {1'b0, m_i, 1'b0};
    sum = {1'b0, r_q, 1'b0} + (bit_i ? {2'b00, a_i} : '0);
    // sum stays below 3m: one of two corrections lands it below m
    if (sum >= m2) begin
      r_d = MOD_W'(sum - m2);
    end else if (sum >= m1) begin
      r_d = MOD_W'(sum - m1);
    end else begin
      r_d = sum[MOD_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_i) begin
      r_q <= '0;
    end else if (step_i) begin
      r_q <= r_d;
    end
  end

  assign r_o = r_q;

endmodule

`default_nettype wire

// ===== rtl/me_ctrl.sv =====
`default_nettype none

module me_ctrl import me_pkg::*; #(
  parameter int unsigned EXP_BITS = EXP_BITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [BASE_W-1:0]   base_value_i,
  input  wire logic [EXP_BITS-1:0] exponent_i,
  input  wire logic                mod_small_i,
  input  wire logic                out_free_i,
  input  wire logic [MOD_W-1:0]    sq_new_i,
  output me_ctl_t                  ctl_o
);

  me_state_e           state_q, state_d;
  logic [STEP_W-1:0]   cnt_q, cnt_d;
  logic [BASE_W-1:0]   bsh_q, bsh_d;
  logic [EXP_BITS-1:0] exp_q, exp_d;
  logic [EXP_BITS-1:0] exp_shr;
  logic                cnt_last;

  assign cnt_last = (cnt_q == STEP_W'(BASE_W - 1));
  assign exp_shr  = exp_q >> 1;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = mod_small_i ? ST_FINISH : ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (cnt_last) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_d = (exp_q == '0) ? ST_FINISH : ST_MUL;
      end
      ST_MUL: begin
        if (cnt_last) begin
          state_d = ST_STORE;
        end
      end
      ST_STORE: begin
        // stop once no set exponent bit remains
        state_d = (exp_shr == '0) ? ST_FINISH : ST_MUL;
      end
      ST_FINISH: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl_o      = '0;
    in_ready_o = 1'b0;
    cnt_d      = cnt_q;
    bsh_d      = bsh_q;
    exp_d      = exp_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.init = 1'b1;
          ctl_o.zero = mod_small_i;
          ctl_o.clr  = 1'b1;
          bsh_d      = base_value_i;
          exp_d      = exponent_i;
          cnt_d      = '0;
        end
      end
      ST_REDUCE: begin
        ctl_o.step   = 1'b1;
        ctl_o.reduce = 1'b1;
        ctl_o.mbit   = bsh_q[BASE_W-1];
        bsh_d        = bsh_q << 1;
        cnt_d        = cnt_q + STEP_W'(1);
      end
      ST_LOAD: begin
        ctl_o.upd_sq = 1'b1;
        ctl_o.clr    = 1'b1;
        bsh_d        = BASE_W'(sq_new_i);
        cnt_d        = '0;
      end
      ST_MUL: begin
        ctl_o.step = 1'b1;
        ctl_o.mbit = bsh_q[BASE_W-1];
        bsh_d      = bsh_q << 1;
        cnt_d      = cnt_q + STEP_W'(1);
      end
      ST_STORE: begin
        ctl_o.upd_sq  = 1'b1;
        ctl_o.upd_acc = exp_q[0];
        ctl_o.clr     = 1'b1;
        exp_d         = exp_shr;
        bsh_d         = BASE_W'(sq_new_i);
        cnt_d         = '0;
      end
      ST_FINISH: begin
        ctl_o.out_load = out_free_i;
      end
      default: begin
        ctl_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bsh_q <= bsh_d;
    exp_q <= exp_d;
  end

endmodule

`default_nettype wire

// ===== rtl/modular_exponentiation.sv =====
// Computes base_value_i ** exponent_i mod the modulus register, right-to-left
// square-and-multiply over the low EXP_BITS exponent bits. The modulus (31 bits,
// reset 1000000007) must be written by the user through the cfg channel only
// while the block is idle; the block itself does not enforce this. cfg_ready_o
// is always high. A modulus below two answers 0. One item is worked at a time:
// after acceptance the base is reduced and loaded as the square, then each
// exponent bit up to the highest set one is worked by two 32-step bit-serial
// modular multipliers running side by side, sharing the shifted multiplier bits,
// followed by an update step; then the result enters the output register. The
// output register lets the next item be accepted while a result waits.
`default_nettype none

`include "assert_macros.svh"

module modular_exponentiation import me_pkg::*; #(
  parameter int unsigned EXP_BITS = EXP_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [MOD_W-1:0]  cfg_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [BASE_W-1:0] base_value_i,
  input  wire logic [EXP_W-1:0]  exponent_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic      [MOD_W-1:0]  power_result_o
);

  me_ctl_t          ctl;
  logic [MOD_W-1:0] modulus_q;
  logic [MOD_W-1:0] acc_q, acc_d;
  logic [MOD_W-1:0] sq_q, sq_d;
  logic [MOD_W-1:0] out_data_q;
  logic             out_valid_q, out_valid_d;
  logic [MOD_W-1:0] acc_r;
  logic [MOD_W-1:0] sq_r;
  logic [MOD_W-1:0] sq_a;
  logic             mod_small;
  logic             out_free;

  assign cfg_ready_o = 1'b1;
  assign mod_small   = (modulus_q < MOD_W'(2));
  assign out_free    = !out_valid_q || out_ready_i;
  assign sq_a        = ctl.reduce ? MOD_W'(1) : sq_q;

  me_ctrl #(
    .EXP_BITS (EXP_BITS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .base_value_i (base_value_i),
    .exponent_i   (exponent_i[EXP_BITS-1:0]),
    .mod_small_i  (mod_small),
    .out_free_i   (out_free),
    .sq_new_i     (sq_r),
    .ctl_o        (ctl)
  );

  me_mulmod u_acc_mul (
    .clk_i  (clk_i),
    .clr_i  (ctl.clr),
    .step_i (ctl.step),
    .bit_i  (ctl.mbit),
    .a_i    (acc_q),
    .m_i    (modulus_q),
    .r_o    (acc_r)
  );

  // during base reduction this unit multiplies one by the base
  me_mulmod u_sq_mul (
    .clk_i  (clk_i),
    .clr_i  (ctl.clr),
    .step_i (ctl.step),
    .bit_i  (ctl.mbit),
    .a_i    (sq_a),
    .m_i    (modulus_q),
    .r_o    (sq_r)
  );

  always_comb begin
    acc_d = acc_q;
    if (ctl.init) begin
      acc_d = ctl.zero ? '0 : MOD_W'(1);
    end else if (ctl.upd_acc) begin
      acc_d = acc_r;
    end
    sq_d = ctl.upd_sq ? sq_r : sq_q;
    if (ctl.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q   <= MODULUS_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        modulus_q <= cfg_data_i;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    sq_q  <= sq_d;
    if (ctl.out_load) begin
      out_data_q <= acc_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign power_result_o = out_data_q;

  `ME_ASSERT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o |=> !in_ready_o, "ready still high after an item was taken")
  `ME_ASSERT(a_result_in_range, clk_i, rst_ni, out_valid_o && !mod_small |-> power_result_o < modulus_q, "result not reduced below modulus")
  `ME_ASSERT(a_load_shows_valid, clk_i, rst_ni, ctl.out_load |=> out_valid_o, "loaded result not presented")

endmodule

`default_nettype wire
